FILE: hw/rtl/sstp_pkg.sv
package sstp_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 4096;
  localparam int TABLE_AW    = $clog2(MAX_ENTRIES);
  localparam int STORED_W    = TABLE_AW + 1;
  localparam int CONSUMED_W  = 15;

  // Request opcodes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_PARSING  = 3'd0;
  localparam logic [2:0] ST_DONE_OK  = 3'd1;
  localparam logic [2:0] ST_DONE_BAD = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_ANSWER   = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  byte_value;
    logic [31:0] sample_index;
  } sstp_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] common_size;
    logic [31:0] entry_count;
    logic [31:0] answer_size;
  } sstp_res_t;

  typedef struct packed {
    logic                wr_en;
    logic [TABLE_AW-1:0] wr_addr;
    logic [31:0]         wr_data;
    logic                rd_en;
    logic [TABLE_AW-1:0] rd_addr;
  } sstp_mem_ctl_t;

endpackage

FILE: hw/rtl/sstp_table.sv
module sstp_table
  import sstp_pkg::*;
(
  input  logic          clk,
  input  sstp_mem_ctl_t ctl,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

FILE: hw/rtl/sample_size_table_parser.sv
// An accepted request is registered into req_q while its table read is issued from req, so
// rd_data is ready in the execute state; that state then loads the result register and sets
// done. busy is high in the execute state, so no new request is taken until the current one
// has committed its result.
// Reset (rst, synchronous) clears the parse state, counters and payload_length; the table
// is not cleared. The receiver cannot stall: each result shows for exactly one cycle.
module sample_size_table_parser
  import sstp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  sstp_req_t             req,
  output logic                  done,
  output sstp_res_t             result,
  input  logic                  cfg_write,
  input  logic [CONSUMED_W-1:0] cfg_data
);

  // Parse phase of the box body
  typedef enum logic [2:0] {
    PH_IDLE, PH_VERS, PH_COMMON, PH_COUNT, PH_ENTRIES, PH_DONE_OK, PH_DONE_BAD, PH_OVERFLOW
  } phase_t;

  // Request sequencer: idle waiting for start, or executing the held request
  typedef enum logic {
    S_IDLE, S_EXEC
  } seq_t;

  seq_t                  seq;
  phase_t                phase, phase_next;
  sstp_req_t             req_q;
  logic [CONSUMED_W-1:0] payload_length;
  logic [CONSUMED_W-1:0] consumed, consumed_next;
  logic [31:0]           assembler, assembler_next;
  logic [1:0]            byte_in_word, byte_in_word_next;
  logic [31:0]           common_size, common_size_next;
  logic [31:0]           entry_count, entry_count_next;
  logic [STORED_W-1:0]   stored, stored_next;
  logic [31:0]           word;
  logic [31:0]           rd_data;
  sstp_mem_ctl_t         mem_ctl;
  sstp_res_t             result_next;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (seq == S_EXEC);

  // Issue the table read straight from the request so the data lands by the execute cycle
  sstp_table u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_data (rd_data)
  );

  // Map a parse phase onto the status it reports
  function automatic logic [2:0] phase_status(phase_t ph);
    logic [2:0] st;
    case (ph)
      PH_DONE_OK:  st = ST_DONE_OK;
      PH_DONE_BAD: st = ST_DONE_BAD;
      PH_OVERFLOW: st = ST_OVERFLOW;
      default:     st = ST_PARSING;
    endcase
    return st;
  endfunction

  // Next parse state for the request held in req_q
  always_comb begin
    phase_next        = phase;
    consumed_next     = consumed;
    assembler_next    = assembler;
    byte_in_word_next = byte_in_word;
    common_size_next  = common_size;
    entry_count_next  = entry_count;
    stored_next       = stored;
    word              = {assembler[23:0], req_q.byte_value};

    mem_ctl.rd_en   = accept;
    mem_ctl.rd_addr = req.sample_index[TABLE_AW-1:0];
    mem_ctl.wr_en   = 1'b0;
    mem_ctl.wr_addr = stored[TABLE_AW-1:0];
    mem_ctl.wr_data = word;

    result_next.answer_size = '0;

    case (req_q.op)
      OP_BEGIN: begin
        // Restart the box: clear everything gathered so far
        phase_next        = PH_VERS;
        consumed_next     = '0;
        assembler_next    = '0;
        byte_in_word_next = '0;
        common_size_next  = '0;
        entry_count_next  = '0;
        stored_next       = '0;
      end
      OP_BYTE: begin
        if (phase inside {PH_VERS, PH_COMMON, PH_COUNT, PH_ENTRIES}) begin
          // Saturate the byte counter at its top value
          if (consumed != '1) begin
            consumed_next = consumed + 1'b1;
          end
          byte_in_word_next = byte_in_word + 2'd1;
          if (byte_in_word != 2'd3) begin
            assembler_next = word;
          end else begin
            // A full big-endian word is in: act on it and drop the assembler
            assembler_next = '0;
            case (phase)
              PH_VERS: begin
                phase_next = PH_COMMON;
              end
              PH_COMMON: begin
                common_size_next = word;
                phase_next       = PH_COUNT;
              end
              PH_COUNT: begin
                entry_count_next = word;
                if (common_size != '0 || word == '0) begin
                  phase_next = (consumed_next == payload_length) ? PH_DONE_OK : PH_DONE_BAD;
                end else if (word > 32'(MAX_ENTRIES)) begin
                  phase_next = PH_OVERFLOW;
                end else begin
                  phase_next = PH_ENTRIES;
                end
              end
              default: begin
                if (stored < STORED_W'(MAX_ENTRIES)) begin
                  // Write only in the execute cycle; outside it req_q is a stale request
                  mem_ctl.wr_en = busy;
                  stored_next   = stored + 1'b1;
                end
                if (32'(stored_next) >= entry_count) begin
                  phase_next = (consumed_next == payload_length) ? PH_DONE_OK : PH_DONE_BAD;
                end
              end
            endcase
          end
        end
      end
      OP_QUERY: begin
        if (common_size != '0) begin
          result_next.answer_size = common_size;
        end else if (req_q.sample_index < 32'(stored)) begin
          result_next.answer_size = rd_data;
        end
      end
      default: begin
      end
    endcase

    result_next.status      = (req_q.op == OP_QUERY) ? ST_ANSWER : phase_status(phase_next);
    result_next.common_size = common_size_next;
    result_next.entry_count = entry_count_next;
  end

  // Sequencer, parse state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= S_IDLE;
      done           <= 1'b0;
      phase          <= PH_IDLE;
      payload_length <= '0;
      consumed       <= '0;
      assembler      <= '0;
      byte_in_word   <= '0;
      common_size    <= '0;
      entry_count    <= '0;
      stored         <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        payload_length <= cfg_data;
      end
      case (seq)
        S_IDLE: begin
          if (accept) begin
            seq <= S_EXEC;
          end
        end
        S_EXEC: begin
          // Commit the request and present its result next cycle
          seq          <= S_IDLE;
          done         <= 1'b1;
          phase        <= phase_next;
          consumed     <= consumed_next;
          assembler    <= assembler_next;
          byte_in_word <= byte_in_word_next;
          common_size  <= common_size_next;
          entry_count  <= entry_count_next;
          stored       <= stored_next;
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request payload and the result payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (seq == S_EXEC) begin
      result <= result_next;
    end
  end

  // Each accepted request enters the execute state, which ends with a single result strobe
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not enter execute");

  a_exec_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("execute cycle did not produce a single result");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result strobe without an execute cycle");

  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= STORED_W'(MAX_ENTRIES))
    else $error("stored entry count past table depth");

  a_no_write_outside_entries: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (busy && phase == PH_ENTRIES))
    else $error("table written outside the entries phase");

endmodule
